// ===== hdl/cbcp_pkg.sv =====
// Shared types and constants for the CAN bridge command parser.
// No dependencies; emitter and parser use it by scoped names.
package cbcp_pkg;

  localparam int CLIENTS       = 4;
  localparam int PAYLOAD_BYTES = 16;
  localparam int CLIENT_W      = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int LANE_W        = $clog2(PAYLOAD_BYTES);
  localparam int MAX_RESULTS   = 20;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] START_BYTE      = 8'hF1;
  localparam logic [7:0] CMD_TRANSMIT    = 8'h00;
  localparam logic [7:0] CMD_TIME_SYNC   = 8'h01;
  localparam logic [7:0] CMD_EXT_BUSES   = 8'h06;
  localparam logic [7:0] CMD_DEV_INFO    = 8'h07;
  localparam logic [7:0] CMD_BUS_ENABLE  = 8'h09;
  localparam logic [7:0] CMD_BUS_DISABLE = 8'h0A;
  localparam logic [7:0] CMD_NUM_BUSES   = 8'h0C;
  localparam logic [7:0] CMD_BINARY_MODE = 8'hE7;

  localparam logic [3:0] TX_PAYLOAD_LEN = 4'd14;
  localparam logic [3:0] MAX_DLC        = 4'd8;

  localparam logic [1:0] MODE_HOST  = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_DISC  = 2'd2;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_TX    = 2'd2;

  localparam logic [1:0] CFG_BUILD  = 2'd0;
  localparam logic [1:0] CFG_BAUD   = 2'd1;
  localparam logic [1:0] CFG_BUSCNT = 2'd2;

  localparam logic [31:0] BUILD_RST  = 32'd333;
  localparam logic [31:0] BAUD_RST   = 32'd500000;
  localparam logic [7:0]  BUSCNT_RST = 8'd1;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_GOT_START = 2'd1,
    PH_COLLECT   = 2'd2
  } phase_e;

  // per-client parser entry
  typedef struct packed {
    phase_e     phase;
    logic [7:0] cmd;
    logic [3:0] count;
  } pstate_t;

  // everything one item emits, handed to the emitter in one go
  typedef struct packed {
    logic [1:0]                  kind;
    logic [1:0]                  client;
    logic [CNT_W-1:0]            cnt;
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [28:0]                 tx_id;
    logic                        tx_ext;
    logic [3:0]                  tx_len;
    logic [63:0]                 tx_bytes;
  } job_t;

endpackage

// ===== hdl/cbcp_item_if.sv =====
// Input channel of the command parser: valid/ready plus one item's fields.
// Standalone; no package needed.
interface cbcp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  client_index;
  logic [7:0]  rx_byte;
  logic [31:0] time_us;
  logic [28:0] frame_id;
  logic        frame_ext;
  logic [3:0]  frame_len;
  logic [63:0] frame_bytes;

  modport source (
    output valid, mode, client_index, rx_byte, time_us,
           frame_id, frame_ext, frame_len, frame_bytes,
    input  ready
  );
  modport sink (
    input  valid, mode, client_index, rx_byte, time_us,
           frame_id, frame_ext, frame_len, frame_bytes,
    output ready
  );
endinterface

// ===== hdl/cbcp_result_if.sv =====
// Result channel of the command parser: valid/ready plus one result beat.
// Standalone; no package needed.
interface cbcp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [1:0]  out_client;
  logic [7:0]  out_byte;
  logic [28:0] tx_id;
  logic        tx_ext;
  logic [3:0]  tx_len;
  logic [63:0] tx_bytes;
  logic        last;

  modport source (
    output valid, out_kind, out_client, out_byte, tx_id, tx_ext,
           tx_len, tx_bytes, last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_client, out_byte, tx_id, tx_ext,
           tx_len, tx_bytes, last,
    output ready
  );
endinterface

// ===== hdl/cbcp_emitter.sv =====
// Output serializer: holds one job, streams a beat per cycle when ready.
// Depends on cbcp_pkg and cbcp_result_if.
module cbcp_emitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cbcp_pkg::job_t job_i,
  input  logic          load_i,
  output logic          can_load_o,
  cbcp_result_if.source res_o
);

  logic           busy_q;
  cbcp_pkg::job_t job_q;
  logic           beat;
  logic           final_beat;

  assign beat       = busy_q && res_o.ready;
  assign final_beat = job_q.cnt == cbcp_pkg::CNT_W'(1);
  assign can_load_o = !busy_q || (res_o.ready && final_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load_i) begin
      busy_q <= 1'b1;
    end else if (beat && final_beat) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end else if (beat) begin
      job_q.bytes <= {8'h00, job_q.bytes[cbcp_pkg::MAX_RESULTS-1:1]};
      job_q.cnt   <= job_q.cnt - cbcp_pkg::CNT_W'(1);
    end
  end

  assign res_o.valid      = busy_q;
  assign res_o.out_kind   = job_q.kind;
  assign res_o.out_client = job_q.client;
  assign res_o.out_byte   = job_q.bytes[0];
  assign res_o.tx_id      = job_q.tx_id;
  assign res_o.tx_ext     = job_q.tx_ext;
  assign res_o.tx_len     = job_q.tx_len;
  assign res_o.tx_bytes   = job_q.tx_bytes;
  assign res_o.last       = final_beat;

endmodule

// ===== hdl/can_bridge_command_parser.sv =====
// CAN bridge command parser: per-client host command parser and bus frame encoder.
// The accepted input beat is registered in stage 1, then its job is loaded into the
// emitter, which presents the first beat. One input beat per cycle while stage 1 can
// advance; an item with N results (up to 20 for an encoded frame) busies the emitter.
// Reset: parser phase/count read as idle/zero via per-client valid bits, config
// registers return to defaults; the payload memory is not cleared.
module can_bridge_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbcp_item_if.sink   item_i,
  cbcp_result_if.source res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int CW = cbcp_pkg::CLIENT_W;
  localparam int LW = cbcp_pkg::LANE_W;
  localparam int PB = cbcp_pkg::PAYLOAD_BYTES;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] build_q;
  logic [31:0] baud_q;
  logic [7:0]  buscnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      build_q  <= cbcp_pkg::BUILD_RST;
      baud_q   <= cbcp_pkg::BAUD_RST;
      buscnt_q <= cbcp_pkg::BUSCNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbcp_pkg::CFG_BUILD:  build_q  <= cfg_data_i;
        cbcp_pkg::CFG_BAUD:   baud_q   <= cfg_data_i;
        cbcp_pkg::CFG_BUSCNT: buscnt_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and stage 1 item registers. The memories are read at the
  // accept edge, so read data lines up with the item in stage 1.
  // ---------------------------------------------------------------------------
  logic          in_acc;
  logic          s1_adv;
  logic [CW-1:0] in_cl;

  logic          s1_valid_q;
  logic [1:0]    s1_mode_q;
  logic [CW-1:0] s1_cl_q;
  logic          s1_ok_q;
  logic [7:0]    s1_byte_q;
  logic [31:0]   s1_time_q;
  logic [28:0]   s1_fid_q;
  logic          s1_fext_q;
  logic [3:0]    s1_flen_q;
  logic [63:0]   s1_fdata_q;

  assign in_acc       = item_i.valid && item_i.ready;
  assign item_i.ready = !s1_valid_q || s1_adv;
  assign in_cl        = CW'(item_i.client_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q  <= item_i.mode;
      s1_cl_q    <= in_cl;
      s1_ok_q    <= int'(item_i.client_index) < cbcp_pkg::CLIENTS;
      s1_byte_q  <= item_i.rx_byte;
      s1_time_q  <= item_i.time_us;
      s1_fid_q   <= item_i.frame_id;
      s1_fext_q  <= item_i.frame_ext;
      s1_flen_q  <= item_i.frame_len;
      s1_fdata_q <= item_i.frame_bytes;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state memory (phase/cmd/count per client) and payload memory
  // (one row of byte lanes per client). Both have a registered read.
  // ---------------------------------------------------------------------------
  cbcp_pkg::pstate_t                st_mem [cbcp_pkg::CLIENTS];
  logic [cbcp_pkg::CLIENTS-1:0]     st_vld_q;
  cbcp_pkg::pstate_t                st_rd_q;
  logic                             st_rd_vld_q;
  logic [PB-1:0][7:0]               pl_mem [cbcp_pkg::CLIENTS];
  logic [PB-1:0][7:0]               pl_rd_q;

  logic              st_we, st_wr;
  logic              pl_we, pl_wr;
  logic [LW-1:0]     pl_lane;
  cbcp_pkg::pstate_t st_nxt;

  assign st_wr = st_we && s1_adv;
  assign pl_wr = pl_we && s1_adv;

  always_ff @(posedge clk_i) begin
    if (st_wr) begin
      st_mem[s1_cl_q] <= st_nxt;
    end
    if (pl_wr) begin
      pl_mem[s1_cl_q][pl_lane] <= s1_byte_q;
    end
    if (in_acc) begin
      st_rd_q <= st_mem[in_cl];
      pl_rd_q <= pl_mem[in_cl];
    end
  end

  // an entry never written reads as idle, count zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q    <= '0;
      st_rd_vld_q <= 1'b0;
    end else begin
      if (st_wr) begin
        st_vld_q[s1_cl_q] <= 1'b1;
      end
      if (in_acc) begin
        st_rd_vld_q <= st_vld_q[in_cl];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Forwarding: the read at an accept edge misses a write at that same edge.
  // Keep the latest write of each memory and lay it over the read data; a
  // write that was already visible is simply applied again.
  // ---------------------------------------------------------------------------
  logic              fst_vld_q;
  logic [CW-1:0]     fst_cl_q;
  cbcp_pkg::pstate_t fst_q;
  logic              fpl_vld_q;
  logic [CW-1:0]     fpl_cl_q;
  logic [LW-1:0]     fpl_lane_q;
  logic [7:0]        fpl_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_vld_q <= 1'b0;
      fpl_vld_q <= 1'b0;
    end else begin
      if (st_wr) fst_vld_q <= 1'b1;
      if (pl_wr) fpl_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_wr) begin
      fst_cl_q <= s1_cl_q;
      fst_q    <= st_nxt;
    end
    if (pl_wr) begin
      fpl_cl_q   <= s1_cl_q;
      fpl_lane_q <= pl_lane;
      fpl_byte_q <= s1_byte_q;
    end
  end

  cbcp_pkg::pstate_t  cur;
  logic [PB-1:0][7:0] pl_row;

  always_comb begin
    if (fst_vld_q && fst_cl_q == s1_cl_q) begin
      cur = fst_q;
    end else if (st_rd_vld_q) begin
      cur = st_rd_q;
    end else begin
      cur = '{phase: cbcp_pkg::PH_IDLE, cmd: 8'h00, count: 4'd0};
    end
    pl_row = pl_rd_q;
    if (fpl_vld_q && fpl_cl_q == s1_cl_q) begin
      pl_row[fpl_lane_q] = fpl_byte_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser step: next entry for this client, payload write, command to run
  // ---------------------------------------------------------------------------
  logic       run_en;
  logic [7:0] run_cmd;
  logic       frame_en;

  always_comb begin
    st_we    = 1'b0;
    st_nxt   = cur;
    pl_we    = 1'b0;
    pl_lane  = LW'(cur.count);
    run_en   = 1'b0;
    run_cmd  = s1_byte_q;
    frame_en = 1'b0;
    if (s1_valid_q) begin
      case (s1_mode_q)
        cbcp_pkg::MODE_HOST: begin
          if (s1_ok_q) begin
            st_we = 1'b1;
            case (cur.phase)
              cbcp_pkg::PH_GOT_START: begin
                st_nxt.cmd   = s1_byte_q;
                st_nxt.count = 4'd0;
                if (s1_byte_q == cbcp_pkg::CMD_TRANSMIT) begin
                  st_nxt.phase = cbcp_pkg::PH_COLLECT;
                end else begin
                  st_nxt.phase = cbcp_pkg::PH_IDLE;
                  run_en       = 1'b1;
                end
              end
              cbcp_pkg::PH_COLLECT: begin
                pl_we        = cur.count < cbcp_pkg::TX_PAYLOAD_LEN;
                st_nxt.count = cur.count + 4'd1;
                if (st_nxt.count >= cbcp_pkg::TX_PAYLOAD_LEN) begin
                  st_nxt.phase = cbcp_pkg::PH_IDLE;
                  run_en       = 1'b1;
                  run_cmd      = cur.cmd;
                end
              end
              default: begin
                st_nxt.phase = (s1_byte_q == cbcp_pkg::START_BYTE) ?
                               cbcp_pkg::PH_GOT_START : cbcp_pkg::PH_IDLE;
              end
            endcase
          end
        end
        cbcp_pkg::MODE_DISC: begin
          if (s1_ok_q) begin
            st_we        = 1'b1;
            st_nxt.phase = cbcp_pkg::PH_IDLE;
          end
        end
        cbcp_pkg::MODE_FRAME: frame_en = 1'b1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Job build: all beats of this item laid out for the emitter
  // ---------------------------------------------------------------------------
  cbcp_pkg::job_t job;
  logic [3:0]     flen;
  logic [31:0]    wire_id;
  logic [31:0]    tx_word;
  logic [3:0]     tx_len;

  always_comb begin
    job     = '0;
    flen    = (s1_flen_q > cbcp_pkg::MAX_DLC) ? cbcp_pkg::MAX_DLC : s1_flen_q;
    wire_id = {s1_fext_q, 2'b00, s1_fid_q};
    tx_word = {pl_row[3], pl_row[2], pl_row[1], pl_row[0]};
    tx_len  = (pl_row[4][3:0] > cbcp_pkg::MAX_DLC) ? cbcp_pkg::MAX_DLC : pl_row[4][3:0];
    if (frame_en) begin
      // F1 00, timestamp, id, length, data, zero checksum
      job.kind      = cbcp_pkg::KIND_FRAME;
      job.bytes[0]  = cbcp_pkg::START_BYTE;
      job.bytes[1]  = 8'h00;
      for (int i = 0; i < 4; i++) begin
        job.bytes[2 + i] = s1_time_q[8*i +: 8];
        job.bytes[6 + i] = wire_id[8*i +: 8];
      end
      job.bytes[10] = {4'h0, flen};
      for (int i = 0; i < 8; i++) begin
        if (i < int'(flen)) begin
          job.bytes[11 + i] = s1_fdata_q[8*i +: 8];
        end
      end
      job.cnt = cbcp_pkg::CNT_W'(12) + cbcp_pkg::CNT_W'(flen);
    end else if (run_en) begin
      job.kind     = cbcp_pkg::KIND_REPLY;
      job.client   = 2'(s1_cl_q);
      job.bytes[0] = cbcp_pkg::START_BYTE;
      job.bytes[1] = run_cmd;
      case (run_cmd)
        cbcp_pkg::CMD_BINARY_MODE,
        cbcp_pkg::CMD_BUS_ENABLE,
        cbcp_pkg::CMD_BUS_DISABLE: job.cnt = cbcp_pkg::CNT_W'(2);
        cbcp_pkg::CMD_TIME_SYNC: begin
          for (int i = 0; i < 4; i++) begin
            job.bytes[2 + i] = s1_time_q[8*i +: 8];
          end
          job.cnt = cbcp_pkg::CNT_W'(6);
        end
        cbcp_pkg::CMD_NUM_BUSES: begin
          job.bytes[2] = buscnt_q;
          job.cnt      = cbcp_pkg::CNT_W'(3);
        end
        cbcp_pkg::CMD_DEV_INFO: begin
          // build, first bus rate, zero second bus, zero single-wire byte
          for (int i = 0; i < 4; i++) begin
            job.bytes[2 + i] = build_q[8*i +: 8];
            job.bytes[6 + i] = baud_q[8*i +: 8];
          end
          job.cnt = cbcp_pkg::CNT_W'(15);
        end
        cbcp_pkg::CMD_EXT_BUSES: job.cnt = cbcp_pkg::CNT_W'(14);
        cbcp_pkg::CMD_TRANSMIT: begin
          job.kind     = cbcp_pkg::KIND_TX;
          job.client   = 2'b00;
          job.bytes[0] = 8'h00;
          job.bytes[1] = 8'h00;
          job.tx_id    = tx_word[28:0];
          job.tx_ext   = tx_word[31];
          job.tx_len   = tx_len;
          for (int i = 0; i < 8; i++) begin
            if (i < int'(tx_len)) begin
              job.tx_bytes[8*i +: 8] = pl_row[5 + i];
            end
          end
          job.cnt = cbcp_pkg::CNT_W'(1);
        end
        default: job.cnt = '0; // unknown command: silently dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Emitter hand-off: an item with no beats leaves stage 1 at once
  // ---------------------------------------------------------------------------
  logic job_empty;
  logic em_can_load;
  logic em_load;

  assign job_empty = job.cnt == '0;
  assign s1_adv    = s1_valid_q && (job_empty || em_can_load);
  assign em_load   = s1_valid_q && !job_empty && em_can_load;

  cbcp_emitter u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job),
    .load_i     (em_load),
    .can_load_o (em_can_load),
    .res_o      (res_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_collect_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_mode_q == cbcp_pkg::MODE_HOST &&
    cur.phase == cbcp_pkg::PH_COLLECT |-> cur.count < cbcp_pkg::TX_PAYLOAD_LEN)
    else $error("collect count reached payload length without completing");

  a_job_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_load |-> job.cnt <= cbcp_pkg::CNT_W'(cbcp_pkg::MAX_RESULTS))
    else $error("job larger than the beat buffer");

  a_tx_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.out_kind == cbcp_pkg::KIND_TX |-> res_o.last)
    else $error("transmit request not the only beat of its item");

  a_client_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.out_kind != cbcp_pkg::KIND_REPLY |-> res_o.out_client == 2'b00)
    else $error("client set on a non-reply beat");

endmodule
